// ----- sv/ppvd_pkg.sv -----
// ppvd_pkg: shared constants and phase type for the pulse peak/valley detector
// no dependencies; used by the stream interfaces and the top level

package ppvd_pkg;

	// sample width and derived limits
	localparam int SAMPLE_BITS = 12;
	localparam logic [SAMPLE_BITS-1:0] SAMPLE_MAX = {SAMPLE_BITS{1'b1}};

	// configuration register layout
	localparam int CFG_BITS = 4;
	localparam int CFG_IDX_BITS = 1;
	localparam logic [CFG_IDX_BITS-1:0] REG_CONFIRM_COUNT = 1'd0;
	localparam logic [CFG_IDX_BITS-1:0] REG_DROP_TENTHS = 1'd1;
	localparam logic [CFG_BITS-1:0] CONFIRM_COUNT_RST = 4'd3;
	localparam logic [CFG_BITS-1:0] DROP_TENTHS_RST = 4'd3;

	// confirmation counter wraps at this width
	localparam int CNT_BITS = 5;

	// width for the drop threshold compare: (sample+1)*10 against peak*tenths
	localparam int THR_BITS = SAMPLE_BITS + 5;
	localparam logic [THR_BITS-1:0] TENTHS_DIV = THR_BITS'(10);

	typedef enum logic [2:0] {
		PH_PEAK   = 3'd0,
		PH_FALL   = 3'd1,
		PH_WAIT   = 3'd2,
		PH_VALLEY = 3'd3,
		PH_RISE   = 3'd4
	} phase_t;

endpackage

// ----- sv/ppvd_sample_if.sv -----
// ppvd_sample_if: valid/ready channel carrying one pulse sample per request
// depends on ppvd_pkg for the sample width

interface ppvd_sample_if import ppvd_pkg::*; ();
	logic                   valid;
	logic                   ready;
	logic [SAMPLE_BITS-1:0] sample;

	modport source (output valid, output sample, input ready);
	modport sink (input valid, input sample, output ready);
endinterface

// ----- sv/ppvd_beat_if.sv -----
// ppvd_beat_if: valid/ready channel carrying one detector result per request
// depends on ppvd_pkg for the sample width

interface ppvd_beat_if import ppvd_pkg::*; ();
	logic                   valid;
	logic                   ready;
	logic                   beat_found;
	logic [SAMPLE_BITS-1:0] peak_value;
	logic [SAMPLE_BITS-1:0] valley_value;
	logic                   beat_indicator;

	modport source (output valid, output beat_found, output peak_value,
		output valley_value, output beat_indicator, input ready);
	modport sink (input valid, input beat_found, input peak_value,
		input valley_value, input beat_indicator, output ready);
endinterface

// ----- sv/pulse_peak_valley_detector.sv -----
// pulse_peak_valley_detector: per-sample peak/valley beat detector, top level
// depends on ppvd_pkg, ppvd_sample_if and ppvd_beat_if

// Each accepted sample produces exactly one result in the next cycle, and a new
// sample can be accepted every cycle: the whole phase update (peak/valley
// tracking, fall/rise confirmation and the drop threshold compare) is done in
// one step between the sample handshake and the result register. The result
// register only holds back new samples while its own result is stalled.
// The drop threshold peak*drop_tenths/10 is compared exactly as
// 10*(sample+1) <= peak*drop_tenths, so no divider is needed. Configuration
// writes (confirm_count, drop_tenths) take effect on the next sample.

module pulse_peak_valley_detector import ppvd_pkg::*; (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    write_en,
	input  logic [CFG_IDX_BITS-1:0] reg_index,
	input  logic [CFG_BITS-1:0]     write_data,
	ppvd_sample_if.sink             samples,
	ppvd_beat_if.source             beats
);

	// configuration registers
	logic [CFG_BITS-1:0] confirm_count_q;
	logic [CFG_BITS-1:0] drop_tenths_q;

	// detector state
	phase_t                 phase_q, phase_d;
	logic [SAMPLE_BITS-1:0] peak_q, peak_d;
	logic [SAMPLE_BITS-1:0] valley_q, valley_d;
	logic [SAMPLE_BITS-1:0] ref_q, ref_d;
	logic [CNT_BITS-1:0]    cnt_q, cnt_d;
	logic                   ind_q, ind_d;

	// result register
	logic                   out_valid_q;
	logic                   beat_q, beat_d;
	logic [SAMPLE_BITS-1:0] pk_out_q, pk_out_d;
	logic [SAMPLE_BITS-1:0] vl_out_q, vl_out_d;
	logic                   ind_out_q;

	logic                   accept;
	logic [SAMPLE_BITS-1:0] s;
	logic [CNT_BITS-1:0]    cnt_inc;
	logic                   cnt_hit;
	logic [THR_BITS-1:0]    scaled_s;
	logic [THR_BITS-1:0]    scaled_pk;
	logic                   below_thr;

	// handshake: take a sample whenever the result register is free or draining
	assign samples.ready = !out_valid_q || beats.ready;
	assign accept = samples.valid && samples.ready;
	assign s = samples.sample;

	assign beats.valid = out_valid_q;
	assign beats.beat_found = beat_q;
	assign beats.peak_value = pk_out_q;
	assign beats.valley_value = vl_out_q;
	assign beats.beat_indicator = ind_out_q;

	// configuration writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			confirm_count_q <= CONFIRM_COUNT_RST;
			drop_tenths_q <= DROP_TENTHS_RST;
		end else if (write_en) begin
			case (reg_index)
				REG_CONFIRM_COUNT: confirm_count_q <= write_data;
				REG_DROP_TENTHS:   drop_tenths_q <= write_data;
				default: ;
			endcase
		end
	end

	// confirmation counter and drop threshold compare
	assign cnt_inc = cnt_q + CNT_BITS'(1);
	assign cnt_hit = (cnt_q == CNT_BITS'(confirm_count_q));
	assign scaled_s = (THR_BITS'(s) + THR_BITS'(1)) * TENTHS_DIV;
	assign scaled_pk = THR_BITS'(peak_q) * THR_BITS'(drop_tenths_q);
	assign below_thr = (scaled_s <= scaled_pk);

	// next state for one sample
	always_comb begin
		phase_d = phase_q;
		peak_d = peak_q;
		valley_d = valley_q;
		ref_d = ref_q;
		cnt_d = cnt_q;
		ind_d = ind_q;
		beat_d = 1'b0;
		pk_out_d = '0;
		vl_out_d = '0;
		case (phase_q)
			PH_FALL: begin
				if (ref_q >= s) begin
					ref_d = s;
					if (cnt_hit) begin
						phase_d = PH_WAIT;
						ind_d = 1'b1;
						ref_d = '0;
					end
				end else begin
					phase_d = PH_PEAK;
					peak_d = '0;
					ref_d = SAMPLE_MAX;
				end
				cnt_d = cnt_inc;
			end
			PH_WAIT: begin
				if (below_thr) begin
					phase_d = PH_VALLEY;
				end
			end
			PH_VALLEY: begin
				if (valley_q >= s) begin
					valley_d = s;
				end else begin
					phase_d = PH_RISE;
					cnt_d = '0;
				end
			end
			PH_RISE: begin
				if (ref_q <= s) begin
					ref_d = s;
					if (cnt_hit) begin
						phase_d = PH_PEAK;
						ind_d = 1'b0;
						beat_d = 1'b1;
						pk_out_d = peak_q;
						vl_out_d = valley_q;
						peak_d = '0;
						valley_d = SAMPLE_MAX;
						ref_d = SAMPLE_MAX;
					end
				end else begin
					phase_d = PH_VALLEY;
					valley_d = SAMPLE_MAX;
					ref_d = '0;
				end
				cnt_d = cnt_inc;
			end
			default: begin
				phase_d = PH_PEAK;
				if (peak_q <= s) begin
					peak_d = s;
				end else begin
					phase_d = PH_FALL;
				end
				cnt_d = '0;
			end
		endcase
	end

	// state update on each accepted sample
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_PEAK;
			peak_q <= '0;
			valley_q <= SAMPLE_MAX;
			ref_q <= SAMPLE_MAX;
			cnt_q <= '0;
			ind_q <= 1'b0;
		end else if (accept) begin
			phase_q <= phase_d;
			peak_q <= peak_d;
			valley_q <= valley_d;
			ref_q <= ref_d;
			cnt_q <= cnt_d;
			ind_q <= ind_d;
		end
	end

	// result valid flag
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (accept) begin
			out_valid_q <= 1'b1;
		end else if (beats.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	// result payload
	always_ff @(posedge clk) begin
		if (accept) begin
			beat_q <= beat_d;
			pk_out_q <= pk_out_d;
			vl_out_q <= vl_out_d;
			ind_out_q <= ind_d;
		end
	end

	// indicator is high exactly in the phases after a confirmed fall
	a_ind_phase: assert property (@(posedge clk) disable iff (!arst_n)
		ind_q == (phase_q == PH_WAIT || phase_q == PH_VALLEY || phase_q == PH_RISE))
		else $error("indicator out of step with phase");

	// a beat clears the indicator in the same result
	a_beat_clears_ind: assert property (@(posedge clk) disable iff (!arst_n)
		(beats.valid && beats.beat_found) |-> !beats.beat_indicator)
		else $error("beat reported with indicator still set");

	// only a sample taken during rise confirmation can complete a beat
	a_beat_from_rise: assert property (@(posedge clk) disable iff (!arst_n)
		(accept && phase_q != PH_RISE) |=> !beats.beat_found)
		else $error("beat outside rise confirmation");

endmodule

// ----- tb/sv/pulse_peak_valley_detector_tb.sv -----
// pulse_peak_valley_detector_tb: self-checking bench for the pulse peak/valley detector
// depends on ppvd_pkg, ppvd_sample_if, ppvd_beat_if and the pulse_peak_valley_detector rtl
// a queue-fed driver sends synthetic pulse trains and noise, the monitor checks each result

module pulse_peak_valley_detector_tb import ppvd_pkg::*; ();

	timeunit 1ns;
	timeprecision 1ps;

	typedef struct {
		logic                   beat_found;
		logic [SAMPLE_BITS-1:0] peak_value;
		logic [SAMPLE_BITS-1:0] valley_value;
		logic                   beat_indicator;
	} beat_rec_t;

	logic clk = 1'b0;
	logic arst_n;
	logic wr_en;
	logic [CFG_IDX_BITS-1:0] wr_idx;
	logic [CFG_BITS-1:0] wr_data;

	ppvd_sample_if samples_if();
	ppvd_beat_if beats_if();

	pulse_peak_valley_detector dut (
		.clk        (clk),
		.arst_n     (arst_n),
		.write_en   (wr_en),
		.reg_index  (wr_idx),
		.write_data (wr_data),
		.samples    (samples_if),
		.beats      (beats_if)
	);

	always #5 clk = ~clk;

	// samples waiting to be sent and results waiting to be seen
	logic [SAMPLE_BITS-1:0] pending_samples[$];
	beat_rec_t expected_beats[$];
	int err_cnt = 0;
	int idle_pct = 0;
	int send_gap = 0;
	int recv_stall = 0;
	int lvl = 0;
	beat_rec_t got_exp;

	// detector state as predicted from the accepted samples
	phase_t ph = PH_PEAK;
	logic [SAMPLE_BITS-1:0] pk_run = '0;
	logic [SAMPLE_BITS-1:0] vl_run = SAMPLE_MAX;
	logic [SAMPLE_BITS-1:0] cref = SAMPLE_MAX;
	logic [CNT_BITS-1:0] cnt = '0;
	logic ind = 1'b0;
	logic [CFG_BITS-1:0] cfg_confirm = CONFIRM_COUNT_RST;
	logic [CFG_BITS-1:0] cfg_tenths = DROP_TENTHS_RST;

	// random idle length: mostly none or short, now and then long
	function automatic int draw_gap();
		int r;
		r = $urandom_range(0, 99);
		if (r >= idle_pct)
			return 0;
		if ($urandom_range(0, 9) == 0)
			return $urandom_range(8, 40);
		return $urandom_range(1, 3);
	endfunction

	// advance the detector by one sample and queue the result it gives
	function automatic void step_detector(logic [SAMPLE_BITS-1:0] s);
		beat_rec_t r;
		r.beat_found = 1'b0;
		r.peak_value = '0;
		r.valley_value = '0;
		case (ph)
			PH_FALL: begin
				if (cref >= s) begin
					cref = s;
					if (cnt == {1'b0, cfg_confirm}) begin
						ph = PH_WAIT;
						ind = 1'b1;
						cref = '0;
					end
				end else begin
					ph = PH_PEAK;
					pk_run = '0;
					cref = SAMPLE_MAX;
				end
				cnt = cnt + 1'b1;
			end
			PH_WAIT: begin
				if (int'(s) < (int'(pk_run) * int'(cfg_tenths)) / 10)
					ph = PH_VALLEY;
			end
			PH_VALLEY: begin
				if (vl_run >= s) begin
					vl_run = s;
				end else begin
					ph = PH_RISE;
					cnt = '0;
				end
			end
			PH_RISE: begin
				if (cref <= s) begin
					cref = s;
					if (cnt == {1'b0, cfg_confirm}) begin
						ph = PH_PEAK;
						ind = 1'b0;
						r.beat_found = 1'b1;
						r.peak_value = pk_run;
						r.valley_value = vl_run;
						pk_run = '0;
						vl_run = SAMPLE_MAX;
						cref = SAMPLE_MAX;
					end
				end else begin
					ph = PH_VALLEY;
					vl_run = SAMPLE_MAX;
					cref = '0;
				end
				cnt = cnt + 1'b1;
			end
			default: begin
				ph = PH_PEAK;
				if (pk_run <= s)
					pk_run = s;
				else
					ph = PH_FALL;
				cnt = '0;
			end
		endcase
		r.beat_indicator = ind;
		expected_beats.push_back(r);
	endfunction

	function automatic void check_field(string name, int exp_v, int act_v);
		if (exp_v != act_v) begin
			$error("%s: expected %0d, got %0d", name, exp_v, act_v);
			err_cnt++;
		end
	endfunction

	// sample driver: predicts on each accepted request, then loads the next
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			samples_if.valid <= 1'b0;
			samples_if.sample <= '0;
			send_gap <= 0;
		end else begin
			if (samples_if.valid && samples_if.ready)
				step_detector(samples_if.sample);
			if (!samples_if.valid || samples_if.ready) begin
				if (send_gap > 0) begin
					samples_if.valid <= 1'b0;
					send_gap <= send_gap - 1;
				end else if (pending_samples.size() > 0) begin
					samples_if.valid <= 1'b1;
					samples_if.sample <= pending_samples.pop_front();
					send_gap <= draw_gap();
				end else begin
					samples_if.valid <= 1'b0;
				end
			end
		end
	end

	// result monitor: compares each accepted request with the oldest prediction
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			beats_if.ready <= 1'b0;
			recv_stall <= 0;
		end else begin
			if (beats_if.valid && beats_if.ready) begin
				if (expected_beats.size() == 0) begin
					$error("result with no sample outstanding");
					err_cnt++;
				end else begin
					got_exp = expected_beats.pop_front();
					check_field("beat_found", got_exp.beat_found, beats_if.beat_found);
					check_field("peak_value", got_exp.peak_value, beats_if.peak_value);
					check_field("valley_value", got_exp.valley_value, beats_if.valley_value);
					check_field("beat_indicator", got_exp.beat_indicator,
						beats_if.beat_indicator);
				end
			end
			if (recv_stall > 0) begin
				beats_if.ready <= 1'b0;
				recv_stall <= recv_stall - 1;
			end else begin
				beats_if.ready <= 1'b1;
				recv_stall <= draw_gap();
			end
		end
	end

	// register write, only issued while the detector is idle
	task automatic write_reg(logic [CFG_IDX_BITS-1:0] idx, logic [CFG_BITS-1:0] val);
		@(posedge clk);
		wr_en <= 1'b1;
		wr_idx <= idx;
		wr_data <= val;
		if (idx == REG_CONFIRM_COUNT)
			cfg_confirm = val;
		else
			cfg_tenths = val;
		@(posedge clk);
		wr_en <= 1'b0;
		@(negedge clk);
	endtask

	// linear ramp with optional jitter that breaks monotonic runs
	task automatic push_ramp(int from_v, int to_v, int steps, bit jitter);
		int v;
		for (int i = 1; i <= steps; i++) begin
			v = from_v + ((to_v - from_v) * i) / steps;
			if (jitter && $urandom_range(0, 9) == 0)
				v = v + int'($urandom_range(0, 200)) - 100;
			if (v < 0)
				v = 0;
			if (v > int'(SAMPLE_MAX))
				v = int'(SAMPLE_MAX);
			pending_samples.push_back(SAMPLE_BITS'(v));
		end
	endtask

	// one pulse: rise to a peak, fall below the drop threshold (below the peak if it is zero or above it), rise again
	task automatic push_pulse(bit jitter);
		int top;
		int lim;
		int bottom;
		top = $urandom_range(lvl > 400 ? lvl : 400, int'(SAMPLE_MAX));
		lim = (cfg_tenths == 0) ? top : (top * int'(cfg_tenths)) / 10;
		if (lim > top)
			lim = top;
		bottom = $urandom_range(0, lim - 1);
		push_ramp(lvl, top, $urandom_range(2, 8), jitter);
		push_ramp(top, bottom, int'(cfg_confirm) + $urandom_range(4, 10), jitter);
		repeat ($urandom_range(1, 3))
			pending_samples.push_back(SAMPLE_BITS'(bottom));
		lvl = bottom + (top - bottom) / 3;
		push_ramp(bottom, lvl, int'(cfg_confirm) + $urandom_range(3, 7), jitter);
	endtask

	task automatic wait_idle();
		do
			@(negedge clk);
		while (pending_samples.size() != 0 || samples_if.valid || expected_beats.size() != 0);
	endtask

	// fill one setting's worth of pulses and noise, then drain
	task automatic run_phase(int budget);
		int r;
		while (pending_samples.size() < budget) begin
			r = $urandom_range(0, 9);
			if (r < 2) begin
				repeat ($urandom_range(3, 10))
					pending_samples.push_back(SAMPLE_BITS'($urandom_range(0, int'(SAMPLE_MAX))));
				lvl = $urandom_range(0, 2000);
			end else begin
				push_pulse(r == 2);
			end
		end
		wait_idle();
	endtask

	// stimulus sequence
	initial begin
		samples_if.valid = 1'b0;
		samples_if.sample = '0;
		beats_if.ready = 1'b0;
		wr_en = 1'b0;
		wr_idx = REG_CONFIRM_COUNT;
		wr_data = '0;
		arst_n = 1'b0;
		repeat (8) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		// reset settings: extremes, fall restart, rise broken by a falling sample
		idle_pct = 30;
		pending_samples = '{12'd0, 12'd4095, 12'd4095, 12'd4000, 12'd4010, 12'd4095,
			12'd3000, 12'd2900, 12'd2900, 12'd2800, 12'd2700, 12'd1500, 12'd1000,
			12'd0, 12'd0, 12'd5, 12'd3, 12'd2, 12'd8, 12'd9, 12'd9, 12'd10,
			12'd11, 12'd12};
		run_phase(70);

		// confirmation count and threshold of one, no idling
		idle_pct = 0;
		write_reg(REG_CONFIRM_COUNT, 4'd1);
		write_reg(REG_DROP_TENTHS, 4'd1);
		run_phase(60);

		// longest confirmation, highest threshold under the peak, heavy idling
		idle_pct = 40;
		write_reg(REG_CONFIRM_COUNT, 4'd15);
		write_reg(REG_DROP_TENTHS, 4'd9);
		run_phase(60);

		// zero confirmation and a threshold above the peak
		idle_pct = 20;
		write_reg(REG_CONFIRM_COUNT, 4'd0);
		write_reg(REG_DROP_TENTHS, 4'd15);
		run_phase(50);

		// random settings
		repeat (3) begin
			case ($urandom_range(0, 2))
				0: idle_pct = 0;
				1: idle_pct = 20;
				default: idle_pct = 50;
			endcase
			write_reg(REG_CONFIRM_COUNT, CFG_BITS'($urandom_range(1, 15)));
			write_reg(REG_DROP_TENTHS, CFG_BITS'($urandom_range(1, 9)));
			run_phase(60);
		end

		// zero threshold: detector parks waiting for the drop
		idle_pct = 15;
		write_reg(REG_CONFIRM_COUNT, CFG_BITS'($urandom_range(1, 15)));
		write_reg(REG_DROP_TENTHS, 4'd0);
		run_phase(30);

		repeat (10) @(negedge clk);
		if (err_cnt == 0)
			$display("DONE: 0 errors");
		else
			$display("DONE: errors detected");
		$finish;
	end

	// run limit
	initial begin
		#5_000_000;
		$display("DONE: errors detected");
		$finish;
	end

endmodule
